// File: sv/eii_pkg.sv
package eii_pkg;

    localparam int ERROR_W   = 16;
    localparam int TIME_W    = 24;
    localparam int PERIOD_W  = 16;
    localparam int ACC_W     = 48;
    localparam int WORD_W    = 32;

    localparam int ERR_FRAC  = 12;
    localparam int TIME_FRAC = 8;
    localparam int DT_FRAC   = 16;
    localparam int ACC_FRAC  = 24;

    // right shifts from the doubled, period-scaled sums to q24.24 (the +1 halves)
    localparam int SH_ISE  = 2 * ERR_FRAC + DT_FRAC - ACC_FRAC + 1;
    localparam int SH_ITSE = 2 * ERR_FRAC + TIME_FRAC + DT_FRAC - ACC_FRAC + 1;
    localparam int SH_IAE  = ERR_FRAC + DT_FRAC - ACC_FRAC + 1;
    localparam int SH_ITAE = ERR_FRAC + TIME_FRAC + DT_FRAC - ACC_FRAC + 1;

    localparam int SQ_W      = 2 * ERROR_W;
    localparam int PRE_W     = SQ_W + TIME_W + 1;
    localparam int ACCUM_W   = PRE_W + PERIOD_W;
    localparam int PROD_W    = 2 * WORD_W;
    localparam int SQ_PAD_W  = 2 * WORD_W;
    localparam int PRE_PAD_W = 3 * WORD_W;
    localparam int SAT_W     = (ACCUM_W > ACC_W ? ACCUM_W : ACC_W) + 1;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(66);

    localparam int                STEP_W    = 5;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(29);

    typedef struct packed {
        logic                      first_sample;
        logic signed [ERROR_W-1:0] error_sample;
        logic        [TIME_W-1:0]  time_stamp;
    } eii_in_t;

    typedef struct packed {
        logic [ACC_W-1:0] ise_value;
        logic [ACC_W-1:0] itse_value;
        logic [ACC_W-1:0] iae_value;
        logic [ACC_W-1:0] itae_value;
    } eii_out_t;

    typedef enum logic [3:0] {
        X_AN, X_AP, X_QN0, X_QN1, X_QP0, X_QP1, X_S0, X_S1, X_S2
    } xsel_t;

    typedef enum logic [2:0] {
        Y_AN, Y_AP, Y_T, Y_TP, Y_DT, Y_ONE
    } ysel_t;

    typedef enum logic [1:0] {
        PD_NONE, PD_QN, PD_QP
    } pdst_t;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_LOAD, ACC_ADD
    } accop_t;

    typedef enum logic [2:0] {
        UPD_NONE, UPD_ISE, UPD_ITSE, UPD_IAE, UPD_ITAE
    } upd_t;

    typedef enum logic [1:0] {
        CTL_NEXT, CTL_BRANCH, CTL_DONE
    } ctl_t;

    typedef struct packed {
        xsel_t      x_sel;
        ysel_t      y_sel;
        pdst_t      p_dst;
        accop_t     acc_op;
        logic [1:0] acc_word;
        logic       s_load;
        upd_t       upd;
        ctl_t       ctl;
    } uword_t;

    typedef struct packed {
        uword_t uw;
        logic   go;
        logic   finish;
        logic   clear;
        logic   in_load;
    } dp_ctrl_t;

    function automatic uword_t uprog(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '{x_sel: X_AN, y_sel: Y_ONE, p_dst: PD_NONE, acc_op: ACC_HOLD,
              acc_word: 2'd0, s_load: 1'b0, upd: UPD_NONE, ctl: CTL_NEXT};
        case (step)
            // ise: squares, their sum, times period
            5'd0: begin
                w.x_sel = X_AN; w.y_sel = Y_AN; w.ctl = CTL_BRANCH;
            end
            5'd1: begin
                w.x_sel = X_AP; w.y_sel = Y_AP; w.p_dst = PD_QN; w.acc_op = ACC_LOAD;
            end
            5'd2: begin
                w.p_dst = PD_QP; w.acc_op = ACC_ADD;
            end
            5'd3: begin
                w.s_load = 1'b1;
            end
            5'd4: begin
                w.x_sel = X_S0; w.y_sel = Y_DT;
            end
            5'd5: begin
                w.x_sel = X_S1; w.y_sel = Y_DT; w.acc_op = ACC_LOAD;
            end
            5'd6: begin
                w.x_sel = X_S2; w.y_sel = Y_DT; w.acc_op = ACC_ADD; w.acc_word = 2'd1;
            end
            5'd7: begin
                w.acc_op = ACC_ADD; w.acc_word = 2'd2; w.x_sel = X_QN0; w.y_sel = Y_T;
            end
            // itse: time-weighted squares
            5'd8: begin
                w.upd = UPD_ISE; w.acc_op = ACC_LOAD; w.x_sel = X_QN1; w.y_sel = Y_T;
            end
            5'd9: begin
                w.acc_op = ACC_ADD; w.acc_word = 2'd1; w.x_sel = X_QP0; w.y_sel = Y_TP;
            end
            5'd10: begin
                w.acc_op = ACC_ADD; w.x_sel = X_QP1; w.y_sel = Y_TP;
            end
            5'd11: begin
                w.acc_op = ACC_ADD; w.acc_word = 2'd1;
            end
            5'd12: begin
                w.s_load = 1'b1;
            end
            5'd13: begin
                w.x_sel = X_S0; w.y_sel = Y_DT;
            end
            5'd14: begin
                w.x_sel = X_S1; w.y_sel = Y_DT; w.acc_op = ACC_LOAD;
            end
            5'd15: begin
                w.x_sel = X_S2; w.y_sel = Y_DT; w.acc_op = ACC_ADD; w.acc_word = 2'd1;
            end
            5'd16: begin
                w.acc_op = ACC_ADD; w.acc_word = 2'd2; w.x_sel = X_AN; w.y_sel = Y_ONE;
            end
            // iae: magnitudes
            5'd17: begin
                w.upd = UPD_ITSE; w.acc_op = ACC_LOAD; w.x_sel = X_AP; w.y_sel = Y_ONE;
            end
            5'd18: begin
                w.acc_op = ACC_ADD;
            end
            5'd19: begin
                w.s_load = 1'b1;
            end
            5'd20: begin
                w.x_sel = X_S0; w.y_sel = Y_DT;
            end
            5'd21: begin
                w.x_sel = X_S1; w.y_sel = Y_DT; w.acc_op = ACC_LOAD;
            end
            5'd22: begin
                w.acc_op = ACC_ADD; w.acc_word = 2'd1; w.x_sel = X_AN; w.y_sel = Y_T;
            end
            // itae: time-weighted magnitudes
            5'd23: begin
                w.upd = UPD_IAE; w.acc_op = ACC_LOAD; w.x_sel = X_AP; w.y_sel = Y_TP;
            end
            5'd24: begin
                w.acc_op = ACC_ADD;
            end
            5'd25: begin
                w.s_load = 1'b1;
            end
            5'd26: begin
                w.x_sel = X_S0; w.y_sel = Y_DT;
            end
            5'd27: begin
                w.x_sel = X_S1; w.y_sel = Y_DT; w.acc_op = ACC_LOAD;
            end
            5'd28: begin
                w.acc_op = ACC_ADD; w.acc_word = 2'd1;
            end
            5'd29: begin
                w.upd = UPD_ITAE; w.ctl = CTL_DONE;
            end
            default: begin
                w.ctl = CTL_DONE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: sv/eii_datapath.sv
module eii_datapath (
    input  logic                              aclk,
    input  eii_pkg::dp_ctrl_t                 ctrl,
    input  eii_pkg::eii_in_t                  in_data,
    input  logic [eii_pkg::PERIOD_W-1:0]      period,
    output eii_pkg::eii_out_t                 result_next
);
    import eii_pkg::*;

    logic [ERROR_W-1:0] err_reg, prev_err_reg;
    logic [TIME_W-1:0]  t_reg, prev_t_reg;
    logic [SQ_W-1:0]    qn_reg, qn_next, qp_reg, qp_next;
    logic [PRE_W-1:0]   pre_reg, pre_next;
    logic [PROD_W-1:0]  p_reg, p_next;
    logic [ACCUM_W-1:0] acc_reg, acc_next;
    logic [ACC_W-1:0]   ise_reg, ise_next, itse_reg, itse_next;
    logic [ACC_W-1:0]   iae_reg, iae_next, itae_reg, itae_next;

    logic [ERROR_W-1:0]        an, ap;
    logic [SQ_PAD_W-1:0]       qn_pad, qp_pad;
    logic [PRE_PAD_W-1:0]      pre_pad;
    logic [WORD_W-1:0]         xop, yop;
    logic [ACCUM_W+PROD_W-1:0] p_wide;
    logic [ACCUM_W-1:0]        acc_add, inc;
    logic [ACC_W-1:0]          cur_sum, new_sum;
    logic [SAT_W-1:0]          total;

    function automatic logic [ERROR_W-1:0] mag(input logic [ERROR_W-1:0] v);
        mag = v[ERROR_W-1] ? (~v + 1'b1) : v;
    endfunction

    assign an      = mag(err_reg);
    assign ap      = mag(prev_err_reg);
    assign qn_pad  = SQ_PAD_W'(qn_reg);
    assign qp_pad  = SQ_PAD_W'(qp_reg);
    assign pre_pad = PRE_PAD_W'(pre_reg);

    always_comb begin
        case (ctrl.uw.x_sel)
            X_AN:    xop = WORD_W'(an);
            X_AP:    xop = WORD_W'(ap);
            X_QN0:   xop = qn_pad[WORD_W-1:0];
            X_QN1:   xop = qn_pad[2*WORD_W-1:WORD_W];
            X_QP0:   xop = qp_pad[WORD_W-1:0];
            X_QP1:   xop = qp_pad[2*WORD_W-1:WORD_W];
            X_S0:    xop = pre_pad[WORD_W-1:0];
            X_S1:    xop = pre_pad[2*WORD_W-1:WORD_W];
            X_S2:    xop = pre_pad[3*WORD_W-1:2*WORD_W];
            default: xop = '0;
        endcase
        case (ctrl.uw.y_sel)
            Y_AN:    yop = WORD_W'(an);
            Y_AP:    yop = WORD_W'(ap);
            Y_T:     yop = WORD_W'(t_reg);
            Y_TP:    yop = WORD_W'(prev_t_reg);
            Y_DT:    yop = WORD_W'(period);
            Y_ONE:   yop = WORD_W'(1);
            default: yop = '0;
        endcase
    end

    assign p_next  = PROD_W'(xop) * PROD_W'(yop);
    assign p_wide  = {{ACCUM_W{1'b0}}, p_reg} << (ctrl.uw.acc_word * WORD_W);
    assign acc_add = p_wide[ACCUM_W-1:0];

    always_comb begin
        acc_next = acc_reg;
        qn_next  = qn_reg;
        qp_next  = qp_reg;
        pre_next = pre_reg;
        if (ctrl.go) begin
            case (ctrl.uw.acc_op)
                ACC_LOAD: acc_next = acc_add;
                ACC_ADD:  acc_next = acc_reg + acc_add;
                default:  acc_next = acc_reg;
            endcase
            case (ctrl.uw.p_dst)
                PD_QN:   qn_next = p_reg[SQ_W-1:0];
                PD_QP:   qp_next = p_reg[SQ_W-1:0];
                default: ;
            endcase
            if (ctrl.uw.s_load) begin
                pre_next = acc_reg[PRE_W-1:0];
            end
        end
    end

    // saturating trapezoid update of one running sum
    always_comb begin
        case (ctrl.uw.upd)
            UPD_ISE: begin
                inc = acc_reg >> SH_ISE;  cur_sum = ise_reg;
            end
            UPD_ITSE: begin
                inc = acc_reg >> SH_ITSE; cur_sum = itse_reg;
            end
            UPD_IAE: begin
                inc = acc_reg >> SH_IAE;  cur_sum = iae_reg;
            end
            UPD_ITAE: begin
                inc = acc_reg >> SH_ITAE; cur_sum = itae_reg;
            end
            default: begin
                inc = '0; cur_sum = '0;
            end
        endcase
        total   = SAT_W'(cur_sum) + SAT_W'(inc);
        new_sum = (total > SAT_W'({ACC_W{1'b1}})) ? {ACC_W{1'b1}} : total[ACC_W-1:0];
    end

    always_comb begin
        ise_next  = ise_reg;
        itse_next = itse_reg;
        iae_next  = iae_reg;
        itae_next = itae_reg;
        if (ctrl.clear) begin
            ise_next  = '0;
            itse_next = '0;
            iae_next  = '0;
            itae_next = '0;
        end else if (ctrl.go) begin
            case (ctrl.uw.upd)
                UPD_ISE:  ise_next  = new_sum;
                UPD_ITSE: itse_next = new_sum;
                UPD_IAE:  iae_next  = new_sum;
                UPD_ITAE: itae_next = new_sum;
                default:  ;
            endcase
        end
    end

    assign result_next.ise_value  = ise_next;
    assign result_next.itse_value = itse_next;
    assign result_next.iae_value  = iae_next;
    assign result_next.itae_value = itae_next;

    always_ff @(posedge aclk) begin
        p_reg    <= p_next;
        acc_reg  <= acc_next;
        qn_reg   <= qn_next;
        qp_reg   <= qp_next;
        pre_reg  <= pre_next;
        ise_reg  <= ise_next;
        itse_reg <= itse_next;
        iae_reg  <= iae_next;
        itae_reg <= itae_next;
        if (ctrl.in_load) begin
            err_reg <= in_data.error_sample;
            t_reg   <= in_data.time_stamp;
        end
        if (ctrl.finish) begin
            prev_err_reg <= err_reg;
            prev_t_reg   <= t_reg;
        end
    end

endmodule

// File: sv/error_integral_indices.sv
// Running ISE, ITSE, IAE and ITAE of a control-error stream, trapezoidal rule scaled by the
// configured sample period, one q24.24 saturating result per input transaction. A sample
// that opens a run (or the first after reset) clears the sums and returns zeros; any other
// sample runs a 30-step microprogram on one shared 32x32 multiplier and accumulator, and
// the next transaction is taken only once its result has been registered. While a result
// waits on m_ready the sequencer holds at its final step.
module error_integral_indices (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  eii_pkg::eii_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output eii_pkg::eii_out_t             m_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [eii_pkg::PERIOD_W-1:0]  cfg_data
);
    import eii_pkg::*;

    logic                busy_reg, busy_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                first_reg, first_next;
    logic                have_prev_reg, have_prev_next;
    logic                m_valid_reg, m_valid_next;
    eii_out_t            m_data_reg, m_data_next;
    logic [PERIOD_W-1:0] period_reg, period_next;

    uword_t   uw;
    dp_ctrl_t ctrl;
    eii_out_t result_next;
    logic     accept, at_done, out_free, go, finish;

    assign uw       = uprog(step_reg);
    assign accept   = s_valid && s_ready;
    assign at_done  = (uw.ctl == CTL_DONE);
    assign out_free = !m_valid_reg || m_ready;
    assign go       = busy_reg && (!at_done || out_free);
    assign finish   = busy_reg && at_done && out_free;

    assign ctrl.uw      = uw;
    assign ctrl.go      = go;
    assign ctrl.finish  = finish;
    assign ctrl.clear   = finish && first_reg;
    assign ctrl.in_load = accept;

    eii_datapath u_datapath (
        .aclk        (aclk),
        .ctrl        (ctrl),
        .in_data     (s_data),
        .period      (period_reg),
        .result_next (result_next)
    );

    always_comb begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        first_next     = first_reg;
        have_prev_next = have_prev_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        period_next    = period_reg;
        if (cfg_valid && cfg_ready) begin
            period_next = cfg_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            busy_next  = 1'b1;
            step_next  = '0;
            first_next = s_data.first_sample || !have_prev_reg;
        end else if (finish) begin
            busy_next      = 1'b0;
            have_prev_next = 1'b1;
            m_valid_next   = 1'b1;
            m_data_next    = result_next;
        end else if (go) begin
            if (uw.ctl == CTL_BRANCH && first_reg) begin
                step_next = LAST_STEP;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            first_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            period_reg    <= PERIOD_RESET;
        end else begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            first_reg     <= first_next;
            have_prev_reg <= have_prev_next;
            m_valid_reg   <= m_valid_next;
            period_reg    <= period_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign s_ready   = !busy_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

endmodule

// File: dv/tb_error_integral_indices.sv
module tb_error_integral_indices;
    import eii_pkg::*;

    localparam int               CYCLE_LIMIT = 500000;
    localparam logic [ACC_W-1:0] ACC_MAX     = '1;

    typedef struct {
        bit                  set_period;
        logic [PERIOD_W-1:0] period;
        eii_in_t             sample;
        bit                  pinned;
        eii_out_t            indices;
    } step_row_t;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    eii_in_t             s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    eii_out_t            m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [PERIOD_W-1:0] cfg_data  = '0;

    // typed-in expectation travelling with the sample on the input channel
    logic     pin_on  = 1'b0;
    eii_out_t pin_val = '0;

    // predictor state
    logic [PERIOD_W-1:0] dt_model   = PERIOD_RESET;
    logic [ERROR_W-1:0]  last_error = '0;
    logic [TIME_W-1:0]   last_time  = '0;
    bit                  run_open   = 1'b0;
    logic [ACC_W-1:0]    ise_acc    = '0;
    logic [ACC_W-1:0]    itse_acc   = '0;
    logic [ACC_W-1:0]    iae_acc    = '0;
    logic [ACC_W-1:0]    itae_acc   = '0;

    eii_out_t  pending_indices [$];
    step_row_t directed_rows [0:19];

    int idle_pct       = 0;
    int stall_pct      = 0;
    int mismatches     = 0;
    int samples_taken  = 0;
    int sets_compared  = 0;
    int runs_opened    = 0;
    int saturated_sets = 0;
    int period_writes  = 0;
    int cycle_count    = 0;

    error_integral_indices DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [127:0] err_mag(logic [ERROR_W-1:0] e);
        logic [16:0] m;
        m = e[ERROR_W-1] ? (17'h10000 - {1'b0, e}) : {1'b0, e};
        return 128'(m);
    endfunction

    function automatic logic [ACC_W-1:0] trapezoid_step(logic [ACC_W-1:0] acc,
                                                        logic [127:0] now_term,
                                                        logic [127:0] last_term,
                                                        int sh, logic [PERIOD_W-1:0] dt);
        logic [127:0] inc;
        inc = ((now_term + last_term) * 128'(dt)) >> sh;
        if (inc > 128'(ACC_MAX - acc)) return ACC_MAX;
        return acc + inc[ACC_W-1:0];
    endfunction

    function automatic eii_out_t integrate_sample(eii_in_t x);
        logic [127:0] an, ap, qn, qp, t_now, t_last;
        eii_out_t r;
        if (x.first_sample || !run_open) begin
            ise_acc  = '0;
            itse_acc = '0;
            iae_acc  = '0;
            itae_acc = '0;
            run_open = 1'b1;
            runs_opened++;
        end else begin
            an       = err_mag(x.error_sample);
            ap       = err_mag(last_error);
            qn       = an * an;
            qp       = ap * ap;
            t_now    = 128'(x.time_stamp);
            t_last   = 128'(last_time);
            ise_acc  = trapezoid_step(ise_acc, qn, qp, SH_ISE, dt_model);
            itse_acc = trapezoid_step(itse_acc, t_now * qn, t_last * qp, SH_ITSE, dt_model);
            iae_acc  = trapezoid_step(iae_acc, an, ap, SH_IAE, dt_model);
            itae_acc = trapezoid_step(itae_acc, t_now * an, t_last * ap, SH_ITAE, dt_model);
        end
        last_error   = x.error_sample;
        last_time    = x.time_stamp;
        r.ise_value  = ise_acc;
        r.itse_value = itse_acc;
        r.iae_value  = iae_acc;
        r.itae_value = itae_acc;
        return r;
    endfunction

    task automatic check_field(string name, logic [ACC_W-1:0] want, logic [ACC_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        eii_out_t predicted;
        eii_out_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                dt_model = cfg_data;
            end
            if (s_valid && s_ready) begin
                predicted = integrate_sample(s_data);
                pending_indices.push_back(pin_on ? pin_val : predicted);
                samples_taken++;
            end
            if (m_valid && m_ready) begin
                if (pending_indices.size() == 0) begin
                    $error("result transaction with no sample pending");
                    mismatches++;
                end else begin
                    want = pending_indices.pop_front();
                    check_field("ise_value", want.ise_value, m_data.ise_value);
                    check_field("itse_value", want.itse_value, m_data.itse_value);
                    check_field("iae_value", want.iae_value, m_data.iae_value);
                    check_field("itae_value", want.itae_value, m_data.itae_value);
                    if (want.itse_value == ACC_MAX || want.itae_value == ACC_MAX ||
                        want.ise_value == ACC_MAX || want.iae_value == ACC_MAX) begin
                        saturated_sets++;
                    end
                    sets_compared++;
                end
            end
        end
    end

    task automatic send_sample(eii_in_t x, bit pinned, eii_out_t pinned_val);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= x;
        pin_on  <= pinned;
        pin_val <= pinned_val;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_period(logic [PERIOD_W-1:0] v);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_indices.size() != 0);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        period_writes++;
    endtask

    function automatic logic [ERROR_W-1:0] pick_error();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    default: return 16'hffff;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] advance_time(logic [TIME_W-1:0] t);
        if (t > 24'hffffff - 24'd4096) return 24'hffffff;
        return t + 24'($urandom_range(1, 4096));
    endfunction

    task automatic random_phase(int count);
        int               made;
        int               len;
        logic [TIME_W-1:0] t;
        eii_in_t          x;
        made = 0;
        t    = 24'($urandom_range(0, 1000));
        // carry on the open run across the period change
        repeat (3) begin
            x = '{1'b0, pick_error(), t};
            send_sample(x, 1'b0, '0);
            t = advance_time(t);
            made++;
        end
        while (made < count) begin
            if ($urandom_range(9) == 0) begin
                x = '{1'($urandom), 16'($urandom), 24'($urandom)};
                send_sample(x, 1'b0, '0);
                made++;
            end else begin
                len = $urandom_range(2, 12);
                t   = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 4095));
                for (int i = 0; i < len; i++) begin
                    x = '{(i == 0), pick_error(), t};
                    send_sample(x, 1'b0, '0);
                    t = advance_time(t);
                    made++;
                end
            end
        end
    endtask

    initial begin
        int                  phase_idle   [4];
        int                  phase_stall  [4];
        logic [PERIOD_W-1:0] phase_period [4];

        directed_rows = '{
            '{1'b0, 16'd0,     '{1'b0, 16'sd1000,   24'd0},       1'b1, '0},
            '{1'b0, 16'd0,     '{1'b0, 16'sh8000,   24'hffffff},  1'b0, '0},
            '{1'b0, 16'd0,     '{1'b0, 16'sh7fff,   24'd0},       1'b0, '0},
            '{1'b0, 16'd0,     '{1'b1, 16'sd0,      24'd100},     1'b1, '0},
            '{1'b0, 16'd0,     '{1'b0, 16'sd0,      24'd200},     1'b1, '0},
            '{1'b1, 16'd0,     '{1'b0, 16'sh7fff,   24'hffffff},  1'b1, '0},
            '{1'b1, 16'hffff,  '{1'b1, 16'sh8000,   24'hffffff},  1'b1, '0},
            '{1'b0, 16'd0,     '{1'b0, 16'sh8000,   24'hffffff},  1'b0, '0},
            '{1'b0, 16'd0,     '{1'b0, 16'sh8000,   24'hffffff},  1'b0, '0},
            '{1'b0, 16'd0,     '{1'b0, 16'sh8000,   24'hffffff},  1'b0, '0},
            '{1'b0, 16'd0,     '{1'b0, 16'sh8000,   24'hffffff},  1'b0, '0},
            '{1'b0, 16'd0,     '{1'b0, 16'sh8000,   24'hffffff},  1'b0, '0},
            '{1'b0, 16'd0,     '{1'b0, 16'sh8000,   24'hffffff},  1'b0, '0},
            '{1'b1, 16'd1,     '{1'b0, 16'sd1,      24'd1},       1'b0, '0},
            '{1'b0, 16'd0,     '{1'b1, 16'shffff,   24'd0},       1'b1, '0},
            '{1'b0, 16'd0,     '{1'b0, 16'shffff,   24'd5},       1'b0, '0},
            '{1'b1, 16'd66,    '{1'b0, 16'sh5555,   24'haaaaaa},  1'b0, '0},
            '{1'b0, 16'd0,     '{1'b0, 16'shaaaa,   24'h555555},  1'b0, '0},
            '{1'b0, 16'd0,     '{1'b1, 16'sh7fff,   24'd0},       1'b1, '0},
            '{1'b0, 16'd0,     '{1'b0, 16'sd0,      24'd0},       1'b0, '0}
        };
        phase_idle   = '{0, 87, 0, 9};
        phase_stall  = '{0, 0, 87, 9};
        phase_period = '{PERIOD_RESET, 16'hffff, 16'd1, 16'($urandom_range(2, 65534))};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].set_period) begin
                write_period(directed_rows[i].period);
            end
            send_sample(directed_rows[i].sample, directed_rows[i].pinned,
                        directed_rows[i].indices);
        end

        for (int p = 0; p < 4; p++) begin
            write_period(phase_period[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            random_phase(125);
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_indices.size() != 0);
        repeat (40) @(posedge aclk);

        $display("%0d samples in %0d runs over %0d period settings, %0d index sets compared",
                 samples_taken, runs_opened, period_writes, sets_compared);
        $display("%0d index sets held at least one saturated integral", saturated_sets);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: error_integral_indices.f
sv/eii_pkg.sv
sv/eii_datapath.sv
sv/error_integral_indices.sv
dv/tb_error_integral_indices.sv
